// ----- hw/rtl/swr_pkg.sv -----
// Shared types and constants for the sample-without-replacement block.
`default_nettype none

package swr_pkg;

  localparam int unsigned CFG_W    = 11;
  localparam int unsigned MEMBER_W = 11;
  localparam int unsigned EPOCH_W  = 8;

  localparam logic CFG_POP_SIZE     = 1'b0;
  localparam logic CFG_SAMPLE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load;
    logic commit;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
    logic epoch_wrap;
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swr_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module swr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swr_ctrl.sv -----
// Controller state machine for the sample-without-replacement block.
`default_nettype none

module swr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire swr_pkg::status_t status_i,
  output swr_pkg::cmd_t         cmd_o
);

  swr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    case (state_q)
      swr_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = swr_pkg::ST_IDLE;
        end
      end
      swr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = swr_pkg::ST_READ;
        end
      end
      swr_pkg::ST_READ: begin
        state_d = swr_pkg::ST_WRITE;
      end
      swr_pkg::ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          if (status_i.last && status_i.epoch_wrap) begin
            state_d = swr_pkg::ST_CLEAR;
          end else begin
            in_stall_o = 1'b0;
            if (in_valid_i) begin
              cmd_o.load = 1'b1;
              state_d    = swr_pkg::ST_READ;
            end else begin
              state_d = swr_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = swr_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swr_dp.sv -----
// Datapath: config registers, slot arithmetic, member table and output register.
`default_nettype none

module swr_dp #(
  parameter int unsigned POP_MAX   = 1024,
  parameter int unsigned RAND_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [swr_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic [31:0]                   random_fraction_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [swr_pkg::MEMBER_W-1:0]       picked_member_o,
  output logic                               last_of_sample_o,
  input  wire swr_pkg::cmd_t                 cmd_i,
  output swr_pkg::status_t                   status_o
);

  localparam int unsigned IW = $clog2(POP_MAX);
  localparam int unsigned CW = $clog2(POP_MAX + 1);
  localparam int unsigned PW = CW + RAND_BITS;
  localparam int unsigned TW = swr_pkg::EPOCH_W + IW;
  localparam int unsigned KW = swr_pkg::CFG_W;

  logic [KW-1:0] pop_size_q, sample_count_q;
  logic [CW-1:0] rem_q, rem_d;
  logic [KW-1:0] drawn_q, drawn_d;
  logic [swr_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IW-1:0] clr_cnt_q, clr_cnt_d;
  logic          last_q, last_d;
  logic [IW-1:0] j_q, lidx_q;
  logic          out_valid_q, out_valid_d;
  logic [swr_pkg::MEMBER_W-1:0] picked_q;
  logic          out_last_q;

  logic [CW-1:0]        eff_pop, rem_eff, rem_new;
  logic [KW-1:0]        eff_cnt, drawn_base, drawn_new;
  logic [RAND_BITS-1:0] frac;
  logic [PW-1:0]        prod;
  logic                 done;
  logic                 clr_last;

  logic          we;
  logic [IW-1:0] waddr;
  logic [TW-1:0] wdata, rd_a, rd_b;
  logic [IW-1:0] val_j, val_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q     <= KW'(1024);
      sample_count_q <= KW'(8);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        swr_pkg::CFG_POP_SIZE:     pop_size_q     <= cfg_data_i;
        swr_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pop_size_q == '0) begin
      eff_pop = CW'(1);
    end else if (32'(pop_size_q) > POP_MAX) begin
      eff_pop = CW'(POP_MAX);
    end else begin
      eff_pop = CW'(pop_size_q);
    end
    if (sample_count_q == '0) begin
      eff_cnt = KW'(1);
    end else if (32'(sample_count_q) > 32'(eff_pop)) begin
      eff_cnt = KW'(eff_pop);
    end else begin
      eff_cnt = sample_count_q;
    end
  end

  assign rem_eff    = (rem_q == '0) ? eff_pop : rem_q;
  assign drawn_base = (rem_q == '0) ? '0 : drawn_q;
  assign frac       = random_fraction_i[31 -: RAND_BITS];
  assign prod       = PW'(rem_eff) * PW'(frac);
  assign rem_new    = rem_eff - CW'(1);
  assign drawn_new  = drawn_base + KW'(1);
  assign done       = (rem_new == '0) || (drawn_new >= eff_cnt);
  assign clr_last   = (clr_cnt_q == IW'(POP_MAX - 1));

  always_comb begin
    rem_d   = rem_q;
    drawn_d = drawn_q;
    last_d  = last_q;
    if (cmd_i.load) begin
      rem_d   = done ? '0 : rem_new;
      drawn_d = done ? '0 : drawn_new;
      last_d  = done;
    end
  end

  always_comb begin
    epoch_d = epoch_q;
    if (cmd_i.clr_wr && clr_last) begin
      epoch_d = swr_pkg::EPOCH_W'(1);
    end else if (cmd_i.commit && last_q) begin
      epoch_d = epoch_q + swr_pkg::EPOCH_W'(1);
    end
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clr_wr) begin
      clr_cnt_d = clr_last ? '0 : clr_cnt_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      drawn_q     <= '0;
      last_q      <= 1'b0;
      epoch_q     <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      drawn_q     <= drawn_d;
      last_q      <= last_d;
      epoch_q     <= epoch_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      j_q    <= prod[RAND_BITS +: IW];
      lidx_q <= IW'(rem_new);
    end
  end

  assign val_j    = (rd_a[TW-1 -: swr_pkg::EPOCH_W] == epoch_q) ? rd_a[IW-1:0] : j_q;
  assign val_last = (rd_b[TW-1 -: swr_pkg::EPOCH_W] == epoch_q) ? rd_b[IW-1:0] : lidx_q;

  assign we    = cmd_i.clr_wr | cmd_i.commit;
  assign waddr = cmd_i.clr_wr ? clr_cnt_q : j_q;
  assign wdata = cmd_i.clr_wr ? '0 : {epoch_q, val_last};

  swr_ram #(
    .WIDTH (TW),
    .DEPTH (POP_MAX)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (j_q),
    .raddr_b_i (lidx_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      picked_q   <= swr_pkg::MEMBER_W'(32'(val_j) + 32'd1);
      out_last_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign picked_member_o  = picked_q;
  assign last_of_sample_o = out_last_q;

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.last       = last_q;
  assign status_o.epoch_wrap = &epoch_q;
  assign status_o.clr_last   = clr_last;

endmodule

`default_nettype wire

// ----- hw/rtl/sample_without_replacement_core.sv -----
// Top level of the sample-without-replacement block (partial Fisher-Yates draw).
//
// Input channel: random_fraction_i with in_valid_i / in_stall_o; one draw per transfer.
// Output channel: picked_member_o (1-based) and last_of_sample_o with out_valid_o /
// out_stall_i; exactly one result per input transfer, in order.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0 pop_size,
// 1 sample_count) and cfg_data_i; always ready, write only while idle.
// Each draw loads j_q and lidx_q, reads the table on both ports in ST_READ, and in
// ST_WRITE, once the output register is free, commits its result there with the
// table write the next draw depends on; the next input can be taken with that commit.
// Slot marks are kept as an epoch tag per table entry. After reset, and after every
// 255 completed samples when the epoch wraps, the table is swept over all POP_MAX
// entries with in_stall_o high; config writes are still taken.
// When the receiver stalls, the result holds in the output register; one more input
// is taken and waits in the datapath until the output register frees.
`default_nettype none

module sample_without_replacement_core #(
  parameter int unsigned POP_MAX   = 1024,
  parameter int unsigned RAND_BITS = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic                      cfg_index_i,
  input  wire logic [swr_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [31:0]               random_fraction_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [swr_pkg::MEMBER_W-1:0]   picked_member_o,
  output logic                           last_of_sample_o
);

  swr_pkg::cmd_t    cmd;
  swr_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  swr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swr_dp #(
    .POP_MAX   (POP_MAX),
    .RAND_BITS (RAND_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .random_fraction_i (random_fraction_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .picked_member_o   (picked_member_o),
    .last_of_sample_o  (last_of_sample_o),
    .cmd_i             (cmd),
    .status_o          (status)
  );

`ifndef SYNTH
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> in_stall_o)
    else $error("table sweep while input open");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(out_valid_o && out_stall_i))
    else $error("result committed over a stalled output");

  a_load_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !cmd.commit && !cmd.load)
    else $error("draw did not wait for its table read");
`endif

endmodule

`default_nettype wire
